// File: design/kqsb_pkg.sv
package kqsb_pkg;

	// Default sizes of the shared slot store and the queue set.
	localparam int SLOT_COUNT  = 64;
	localparam int QUEUE_COUNT = 8;
	localparam int DATA_WIDTH  = 32;

	// Widths of the stream fields.
	localparam int CMD_W   = 2;
	localparam int QIDX_W  = 3;
	localparam int VALUE_W = 32;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	// Command codes carried in the input tuser field.
	localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STATUS  = 2'd2;

endpackage

// File: design/kqsb_ram.sv
module kqsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read-first: a read and a write of one address in one cycle return the old word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/k_queues_shared_buffer.sv
// k_queues_shared_buffer: several FIFO queues kept as linked lists in one shared slot store.
// A taken command waits in the input stage register until it fires into the output register.
// Throughput: one command per cycle, set by the single pass from the input stage register
// through the pointer logic into the output register; a stalled output holds the input stage.
// Reset (arst_n low, asynchronous) empties every queue and frees every slot at once; no
// clearing pass runs over the slot store, so commands are taken as soon as reset is released.
module k_queues_shared_buffer #(
	parameter int SLOT_COUNT  = kqsb_pkg::SLOT_COUNT,
	parameter int QUEUE_COUNT = kqsb_pkg::QUEUE_COUNT,
	parameter int DATA_WIDTH  = kqsb_pkg::DATA_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Command stream.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// Fields from bit 0 up: queue_index (3), value (32, signed), zero fill (5).
	input  logic [kqsb_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// Fields from bit 0 up: command (2).
	input  logic [kqsb_pkg::CMD_W-1:0]     s_axis_tuser,
	// Result stream.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// Fields from bit 0 up: read_value (32, signed), read_ok (1), write_ok (1),
	// named_queue_empty (1), store_full (1), zero fill (4).
	output logic [kqsb_pkg::M_TDATA_W-1:0] m_axis_tdata
);

	// Slot index, slot count and queue index widths.
	localparam int IW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int VW = kqsb_pkg::VALUE_W;

	// Slots are handed out from two sources. Slots at or above fresh_q were never used and
	// are taken in order. Slots freed by a dequeue are pushed onto a free list that is
	// threaded through the link store itself; free_head_q is its top. The free list holds
	// fresh_q - used_q entries, so no per-slot used bit is needed. Which slot a word lands
	// in never shows at the ports; only the FIFO order per queue does.

	// Queue pointers and occupancy.
	logic [IW-1:0]          head_q [QUEUE_COUNT];
	logic [IW-1:0]          tail_q [QUEUE_COUNT];
	logic [QUEUE_COUNT-1:0] occ_q;
	logic [CW-1:0]          used_q;
	logic [CW-1:0]          fresh_q;
	logic [IW-1:0]          free_head_q;

	// Input stage: the command plus the head of its queue, captured as the stores are read.
	logic                          s1_valid;
	logic [kqsb_pkg::CMD_W-1:0]    cmd_s1;
	logic [kqsb_pkg::QIDX_W-1:0]   qnum_s1;
	logic [DATA_WIDTH-1:0]         val_s1;
	logic [IW-1:0]                 head_s1;
	// Bypass of words written at the very edge the stores were read.
	logic                          byp_a_link_s1;
	logic [IW-1:0]                 byp_a_link_val_s1;
	logic                          byp_a_data_s1;
	logic [DATA_WIDTH-1:0]         byp_a_data_val_s1;
	logic                          byp_b_link_s1;
	logic [IW-1:0]                 byp_b_link_val_s1;

	// Output register.
	logic                          out_valid_q;
	logic [kqsb_pkg::M_TDATA_W-1:0] out_data_q;

	// Store read data.
	logic [DATA_WIDTH-1:0] data_a_rd;
	logic [IW-1:0]         link_a_rd;
	logic [IW-1:0]         link_b_rd;

	// Handshake.
	logic s1_fire;
	logic accept;

	assign s1_fire       = s1_valid && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid || s1_fire;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Incoming word fields.
	logic [kqsb_pkg::QIDX_W-1:0] qnum_in;
	logic [VW-1:0]               value_in;
	logic [DATA_WIDTH-1:0]       value_store;
	logic                        qin_ok;
	logic [QW-1:0]               qin_idx;

	assign qnum_in  = s_axis_tdata[kqsb_pkg::QIDX_W-1:0];
	assign value_in = s_axis_tdata[kqsb_pkg::QIDX_W +: VW];
	assign qin_ok   = 32'(qnum_in) < 32'(QUEUE_COUNT);
	assign qin_idx  = QW'(qnum_in);

	// The store keeps the low DATA_WIDTH bits of the value; a wider store is zero-filled.
	generate
		if (DATA_WIDTH <= VW) begin : g_store_narrow
			assign value_store = value_in[DATA_WIDTH-1:0];
		end else begin : g_store_wide
			assign value_store = {{(DATA_WIDTH - VW){1'b0}}, value_in};
		end
	endgenerate

	// Stage logic, all for the command in the input stage.
	logic                  q_ok;
	logic [QW-1:0]         q_idx;
	logic                  is_enq;
	logic                  is_deq;
	logic                  occ_cur;
	logic [IW-1:0]         tail_cur;
	logic                  free_avail;
	logic                  fresh_avail;
	logic                  do_enq;
	logic                  do_deq;
	logic                  last_elem;
	logic [IW-1:0]         alloc_slot;
	logic [DATA_WIDTH-1:0] data_a;
	logic [IW-1:0]         link_a;
	logic [IW-1:0]         link_b;
	logic                  occ_after;
	logic [CW-1:0]         used_d;
	logic [VW-1:0]         deq_value;
	logic [VW-1:0]         read_value;

	assign q_ok  = 32'(qnum_s1) < 32'(QUEUE_COUNT);
	assign q_idx = QW'(qnum_s1);

	always_comb begin
		is_enq = 1'b0;
		is_deq = 1'b0;
		unique case (cmd_s1)
			kqsb_pkg::CMD_ENQUEUE: is_enq = q_ok;
			kqsb_pkg::CMD_DEQUEUE: is_deq = q_ok;
			default: begin
				// Status query and the unused code change nothing.
			end
		endcase
	end

	assign occ_cur     = q_ok ? occ_q[q_idx] : 1'b0;
	assign tail_cur    = q_ok ? tail_q[q_idx] : '0;
	assign free_avail  = used_q < fresh_q;
	assign fresh_avail = fresh_q < CW'(SLOT_COUNT);
	assign do_enq      = is_enq && (free_avail || fresh_avail);
	assign do_deq      = is_deq && occ_cur;
	assign last_elem   = head_s1 == tail_cur;
	assign alloc_slot  = free_avail ? free_head_q : fresh_q[IW-1:0];

	assign data_a = byp_a_data_s1 ? byp_a_data_val_s1 : data_a_rd;
	assign link_a = byp_a_link_s1 ? byp_a_link_val_s1 : link_a_rd;
	assign link_b = byp_b_link_s1 ? byp_b_link_val_s1 : link_b_rd;

	// Store writes and pointer updates, all taking effect when the stage fires.
	logic                  dw_en;
	logic [IW-1:0]         dw_addr;
	logic [DATA_WIDTH-1:0] dw_data;
	logic                  lw_en;
	logic [IW-1:0]         lw_addr;
	logic [IW-1:0]         lw_data;
	logic                  hd_en;
	logic [IW-1:0]         hd_val;
	logic [IW-1:0]         free_head_d;
	logic [CW-1:0]         fresh_d;

	assign dw_en   = s1_fire && do_enq;
	assign dw_addr = alloc_slot;
	assign dw_data = val_s1;

	// A dequeue pushes the freed head onto the free list; an enqueue behind a tail links
	// the new slot after it. Only one of them happens per command.
	assign lw_en   = s1_fire && (do_deq || (do_enq && occ_cur));
	assign lw_addr = do_deq ? head_s1 : tail_cur;
	assign lw_data = do_deq ? free_head_q : alloc_slot;

	assign hd_en  = s1_fire && ((do_deq && !last_elem) || (do_enq && !occ_cur));
	assign hd_val = do_deq ? link_a : alloc_slot;

	always_comb begin
		free_head_d = free_head_q;
		fresh_d     = fresh_q;
		if (s1_fire && do_deq) begin
			free_head_d = head_s1;
		end else if (s1_fire && do_enq) begin
			if (free_avail) begin
				free_head_d = link_b;
			end else begin
				fresh_d = fresh_q + CW'(1);
			end
		end
	end

	always_comb begin
		used_d = used_q;
		if (do_enq) begin
			used_d = used_q + CW'(1);
		end else if (do_deq) begin
			used_d = used_q - CW'(1);
		end
	end

	assign occ_after = do_enq ? 1'b1 : ((do_deq && last_elem) ? 1'b0 : occ_cur);

	// Dequeued word sign-extended from the stored width to the port width, or cut down to it.
	generate
		if (DATA_WIDTH < VW) begin : g_out_narrow
			assign deq_value = {{(VW - DATA_WIDTH){data_a[DATA_WIDTH-1]}}, data_a};
		end else begin : g_out_wide
			assign deq_value = data_a[VW-1:0];
		end
	endgenerate

	assign read_value = do_deq ? deq_value : '1;

	// Read addresses for the incoming word: the head of its queue and the top of the free
	// list, both as they stand after the command now leaving the input stage.
	logic [IW-1:0] rd_addr_a;
	logic [IW-1:0] rd_addr_b;

	always_comb begin
		rd_addr_a = qin_ok ? head_q[qin_idx] : '0;
		if (hd_en && (qnum_s1 == qnum_in)) begin
			rd_addr_a = hd_val;
		end
	end

	assign rd_addr_b = free_head_d;

	kqsb_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(SLOT_COUNT)
	) u_data_ram (
		.clk    (clk),
		.wr_en  (dw_en),
		.wr_addr(dw_addr),
		.wr_data(dw_data),
		.rd_en  (accept),
		.rd_addr(rd_addr_a),
		.rd_data(data_a_rd)
	);

	// Two copies of the link store, written alike, give the two read ports.
	kqsb_ram #(
		.WIDTH(IW),
		.DEPTH(SLOT_COUNT)
	) u_link_ram_a (
		.clk    (clk),
		.wr_en  (lw_en),
		.wr_addr(lw_addr),
		.wr_data(lw_data),
		.rd_en  (accept),
		.rd_addr(rd_addr_a),
		.rd_data(link_a_rd)
	);

	kqsb_ram #(
		.WIDTH(IW),
		.DEPTH(SLOT_COUNT)
	) u_link_ram_b (
		.clk    (clk),
		.wr_en  (lw_en),
		.wr_addr(lw_addr),
		.wr_data(lw_data),
		.rd_en  (accept),
		.rd_addr(rd_addr_b),
		.rd_data(link_b_rd)
	);

	// Input stage payload and bypass capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1            <= s_axis_tuser;
			qnum_s1           <= qnum_in;
			val_s1            <= value_store;
			head_s1           <= rd_addr_a;
			byp_a_link_s1     <= lw_en && (lw_addr == rd_addr_a);
			byp_a_link_val_s1 <= lw_data;
			byp_a_data_s1     <= dw_en && (dw_addr == rd_addr_a);
			byp_a_data_val_s1 <= dw_data;
			byp_b_link_s1     <= lw_en && (lw_addr == rd_addr_b);
			byp_b_link_val_s1 <= lw_data;
		end
	end

	// Queue pointers need no reset: they are read only for an occupied queue.
	always_ff @(posedge clk) begin
		if (hd_en) begin
			head_q[q_idx] <= hd_val;
		end
		if (s1_fire && do_enq) begin
			tail_q[q_idx] <= alloc_slot;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
			occ_q       <= '0;
			used_q      <= '0;
			fresh_q     <= '0;
			free_head_q <= '0;
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_fire) begin
				s1_valid <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				used_q <= used_d;
				if (do_enq || do_deq) begin
					occ_q[q_idx] <= occ_after;
				end
			end
			fresh_q     <= fresh_d;
			free_head_q <= free_head_d;
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_data_q <= {4'b0000,
				used_d == CW'(SLOT_COUNT),
				!q_ok || !occ_after,
				do_enq,
				do_deq,
				read_value};
		end
	end

endmodule

// File: sim/tb_k_queues_shared_buffer.sv
module tb_k_queues_shared_buffer;

	// The unused command code behaves as a status query.
	localparam logic [kqsb_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

	localparam int SLOT_W       = $clog2(kqsb_pkg::SLOT_COUNT);
	localparam int RANDOM_WORDS = 1100;
	// Cycles without any accepted word before the run is declared hung.
	localparam int STALL_LIMIT  = 2000;
	// Cycles waited at the end so that a stray result word after the last one is still seen.
	localparam int DRAIN_CYCLES = 10;

	typedef logic [SLOT_W-1:0] slot_t;

	// One result word, split into the fields of the master-side tdata.
	typedef struct packed {
		logic [kqsb_pkg::VALUE_W-1:0] read_value;
		logic                         read_ok;
		logic                         write_ok;
		logic                         queue_empty;
		logic                         store_full;
	} result_t;

	// One command word. Rows marked typed carry an expectation written by hand.
	typedef struct {
		logic [kqsb_pkg::CMD_W-1:0]   command;
		logic [kqsb_pkg::QIDX_W-1:0]  queue_index;
		logic [kqsb_pkg::VALUE_W-1:0] value;
		bit                           typed;
		result_t                      known;
	} command_word_t;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} traffic_mode_t;

	// Nothing returned, nothing stored, queue empty, store not full.
	localparam result_t IDLE_EMPTY = {32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0};
	// A stored value into a store that still has room.
	localparam result_t STORED     = {32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0};
	localparam result_t UNTYPED    = '0;

	// The directed part. It starts from reset and leaves every queue empty again.
	// It covers a dequeue from an empty queue, the spare command code, both data
	// extremes, and the all-ones value stored and returned as ordinary data.
	command_word_t directed_table [24] = '{
		'{kqsb_pkg::CMD_DEQUEUE, 3'd0, 32'h0000_0000, 1'b1, IDLE_EMPTY},
		'{kqsb_pkg::CMD_STATUS,  3'd7, 32'hFFFF_FFFF, 1'b1, IDLE_EMPTY},
		'{CMD_SPARE,             3'd5, 32'h8000_0000, 1'b1, IDLE_EMPTY},
		'{kqsb_pkg::CMD_ENQUEUE, 3'd0, 32'h7FFF_FFFF, 1'b1, STORED},
		'{kqsb_pkg::CMD_ENQUEUE, 3'd0, 32'h8000_0000, 1'b1, STORED},
		'{kqsb_pkg::CMD_ENQUEUE, 3'd7, 32'hFFFF_FFFF, 1'b1, STORED},
		'{kqsb_pkg::CMD_ENQUEUE, 3'd7, 32'h0000_0000, 1'b1, STORED},
		'{kqsb_pkg::CMD_STATUS,  3'd0, 32'h0000_0000, 1'b1,
			{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{kqsb_pkg::CMD_DEQUEUE, 3'd0, 32'h0000_0000, 1'b1,
			{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{kqsb_pkg::CMD_ENQUEUE, 3'd3, 32'h1234_5678, 1'b0, UNTYPED},
		'{kqsb_pkg::CMD_DEQUEUE, 3'd7, 32'h0000_0000, 1'b1,
			{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{kqsb_pkg::CMD_DEQUEUE, 3'd0, 32'h0000_0000, 1'b1,
			{32'h8000_0000, 1'b1, 1'b0, 1'b1, 1'b0}},
		'{kqsb_pkg::CMD_DEQUEUE, 3'd0, 32'h0000_0000, 1'b1, IDLE_EMPTY},
		'{kqsb_pkg::CMD_ENQUEUE, 3'd1, 32'h5555_5555, 1'b0, UNTYPED},
		'{kqsb_pkg::CMD_ENQUEUE, 3'd2, 32'hAAAA_AAAA, 1'b0, UNTYPED},
		'{kqsb_pkg::CMD_ENQUEUE, 3'd1, 32'hA5A5_A5A5, 1'b0, UNTYPED},
		'{kqsb_pkg::CMD_DEQUEUE, 3'd7, 32'h0000_0000, 1'b0, UNTYPED},
		'{kqsb_pkg::CMD_DEQUEUE, 3'd3, 32'h0000_0000, 1'b0, UNTYPED},
		'{kqsb_pkg::CMD_DEQUEUE, 3'd2, 32'h0000_0000, 1'b0, UNTYPED},
		'{kqsb_pkg::CMD_DEQUEUE, 3'd1, 32'h0000_0000, 1'b0, UNTYPED},
		'{kqsb_pkg::CMD_STATUS,  3'd1, 32'h0000_0000, 1'b0, UNTYPED},
		'{kqsb_pkg::CMD_DEQUEUE, 3'd1, 32'h0000_0000, 1'b0, UNTYPED},
		'{kqsb_pkg::CMD_DEQUEUE, 3'd1, 32'h0000_0000, 1'b0, UNTYPED},
		'{CMD_SPARE,             3'd4, 32'h0000_0000, 1'b0, UNTYPED}
	};

	logic [kqsb_pkg::VALUE_W-1:0] corner_values [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
		32'h7FFF_FFFF, 32'h8000_0000};

	// Idle percentages per phase: receiver slow first, then sender slow, then neither.
	int send_idle_pct [3] = '{37, 78, 0};
	int recv_idle_pct [3] = '{78, 37, 0};

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [kqsb_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
	logic [kqsb_pkg::CMD_W-1:0]       s_axis_tuser = '0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [kqsb_pkg::M_TDATA_W-1:0]   m_axis_tdata;

	// Shadow of the shared slot store and the per-queue pointers.
	logic [kqsb_pkg::VALUE_W-1:0] slot_value [kqsb_pkg::SLOT_COUNT];
	slot_t                        slot_next  [kqsb_pkg::SLOT_COUNT];
	bit                           slot_busy  [kqsb_pkg::SLOT_COUNT];
	slot_t                        head_slot  [kqsb_pkg::QUEUE_COUNT];
	slot_t                        tail_slot  [kqsb_pkg::QUEUE_COUNT];
	bit                           queue_live [kqsb_pkg::QUEUE_COUNT];

	// Queue lengths as the stimulus plan sees them, used only to shape traffic.
	int plan_len [kqsb_pkg::QUEUE_COUNT];
	int plan_used = 0;

	command_word_t command_words [$];
	result_t       pending_results [$];
	result_t       sent_result;
	result_t       oldest_result;
	int            next_word = 0;
	int            sent_count = 0;
	int            idle_phase = 0;
	int            mismatch_count = 0;
	int            stall_cycles;

	k_queues_shared_buffer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	// Applies one command to the shadow store and returns the result word it yields.
	// An enqueue takes the lowest free slot and links it behind the tail; a dequeue
	// frees the head slot and follows its link. Everything else leaves state alone.
	function automatic result_t queue_store_step(logic [kqsb_pkg::CMD_W-1:0] command,
			logic [kqsb_pkg::QIDX_W-1:0] qi, logic [kqsb_pkg::VALUE_W-1:0] value);
		result_t r;
		slot_t   s;
		slot_t   h;
		bit      found;
		bit      full;
		int      i;
		r = IDLE_EMPTY;
		found = 1'b0;
		s = '0;
		if (qi < kqsb_pkg::QUEUE_COUNT) begin
			if (command == kqsb_pkg::CMD_ENQUEUE) begin
				// Scanning downward leaves the lowest free slot in s.
				for (i = kqsb_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
					if (!slot_busy[i]) begin
						found = 1'b1;
						s = slot_t'(i);
					end
				end
				if (found) begin
					slot_value[s] = value;
					slot_next[s] = '0;
					slot_busy[s] = 1'b1;
					if (queue_live[qi]) begin
						slot_next[tail_slot[qi]] = s;
					end else begin
						head_slot[qi] = s;
						queue_live[qi] = 1'b1;
					end
					tail_slot[qi] = s;
					r.write_ok = 1'b1;
				end
			end else if (command == kqsb_pkg::CMD_DEQUEUE && queue_live[qi]) begin
				h = head_slot[qi];
				r.read_value = slot_value[h];
				r.read_ok = 1'b1;
				slot_busy[h] = 1'b0;
				if (h == tail_slot[qi]) begin
					queue_live[qi] = 1'b0;
				end else begin
					head_slot[qi] = slot_next[h];
				end
			end
			r.queue_empty = !queue_live[qi];
		end
		full = 1'b1;
		for (i = 0; i < kqsb_pkg::SLOT_COUNT; i++) begin
			if (!slot_busy[i]) begin
				full = 1'b0;
			end
		end
		r.store_full = full;
		return r;
	endfunction

	// Appends a word to the stimulus and keeps the planned queue lengths current,
	// so that random dequeues can be aimed at queues that hold something.
	task automatic push_word(command_word_t w);
		command_words.push_back(w);
		if (w.command == kqsb_pkg::CMD_ENQUEUE && plan_used < kqsb_pkg::SLOT_COUNT) begin
			plan_len[w.queue_index]++;
			plan_used++;
		end else if (w.command == kqsb_pkg::CMD_DEQUEUE && plan_len[w.queue_index] > 0) begin
			plan_len[w.queue_index]--;
			plan_used--;
		end
	endtask

	task automatic check_field(string field, logic [kqsb_pkg::VALUE_W-1:0] want,
			logic [kqsb_pkg::VALUE_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", field, want, got);
			mismatch_count++;
		end
	endtask

	// Sender. A word is taken at an edge where tvalid and tready are both high;
	// its expected result is worked out right then. A new word, or an idle gap,
	// is only put on the bus once the current word has been taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				sent_result = queue_store_step(command_words[sent_count].command,
					command_words[sent_count].queue_index,
					command_words[sent_count].value);
				if (command_words[sent_count].typed) begin
					pending_results.push_back(command_words[sent_count].known);
				end else begin
					pending_results.push_back(sent_result);
				end
				sent_count++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (next_word < command_words.size() &&
						$urandom_range(99) >= send_idle_pct[idle_phase]) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= command_words[next_word].command;
					s_axis_tdata <= {{(kqsb_pkg::S_TDATA_W - kqsb_pkg::QIDX_W -
						kqsb_pkg::VALUE_W){1'b0}},
						command_words[next_word].value,
						command_words[next_word].queue_index};
					next_word++;
					idle_phase <= (next_word * 3 >= 2 * command_words.size()) ? 2 :
						(next_word * 3 >= command_words.size()) ? 1 : 0;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Each taken result word is compared field by field with the oldest
	// expectation. The receiver may drop tready at any edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$error("result word %h arrived with no command waiting for it",
						m_axis_tdata);
					mismatch_count++;
				end else begin
					oldest_result = pending_results.pop_front();
					check_field("read_value", oldest_result.read_value,
						m_axis_tdata[kqsb_pkg::VALUE_W-1:0]);
					check_field("read_ok", oldest_result.read_ok,
						m_axis_tdata[kqsb_pkg::VALUE_W]);
					check_field("write_ok", oldest_result.write_ok,
						m_axis_tdata[kqsb_pkg::VALUE_W+1]);
					check_field("named_queue_empty", oldest_result.queue_empty,
						m_axis_tdata[kqsb_pkg::VALUE_W+2]);
					check_field("store_full", oldest_result.store_full,
						m_axis_tdata[kqsb_pkg::VALUE_W+3]);
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct[idle_phase]);
		end
	end

	// Watchdog: the run is hung when no word moves on either side for too long.
	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		command_word_t w;
		traffic_mode_t mode;
		int            burst;
		int            left;
		int            start;
		int            pick;
		int            roll;
		foreach (directed_table[i]) begin
			push_word(directed_table[i]);
		end

		// Random traffic comes in bursts of one kind. Fill bursts push the store
		// to full so that enqueues get dropped; drain bursts empty it again and run
		// into empty queues; noise bursts use any code on any queue. The first burst
		// is a long fill so the full store is reached early.
		mode = MODE_FILL;
		burst = 110;
		left = RANDOM_WORDS;
		while (left > 0) begin
			while (burst > 0 && left > 0) begin
				w.typed = 1'b0;
				w.known = UNTYPED;
				w.queue_index = kqsb_pkg::QIDX_W'($urandom_range(kqsb_pkg::QUEUE_COUNT - 1));
				w.value = ($urandom_range(9) == 0) ? corner_values[$urandom_range(3)] :
					$urandom();
				roll = $urandom_range(99);
				case (mode)
				MODE_FILL: begin
					w.command = (roll < 85) ? kqsb_pkg::CMD_ENQUEUE : kqsb_pkg::CMD_DEQUEUE;
				end
				MODE_DRAIN: begin
					w.command = (roll < 85) ? kqsb_pkg::CMD_DEQUEUE : kqsb_pkg::CMD_ENQUEUE;
				end
				MODE_MIXED: begin
					w.command = (roll < 46) ? kqsb_pkg::CMD_ENQUEUE :
						(roll < 92) ? kqsb_pkg::CMD_DEQUEUE : kqsb_pkg::CMD_STATUS;
				end
				default: begin
					w.command = kqsb_pkg::CMD_W'($urandom_range(3));
				end
				endcase
				// Outside noise, aim a dequeue at a queue that holds something,
				// when there is one.
				if (mode != MODE_NOISE && w.command == kqsb_pkg::CMD_DEQUEUE) begin
					start = $urandom_range(kqsb_pkg::QUEUE_COUNT - 1);
					pick = 0;
					while (pick < kqsb_pkg::QUEUE_COUNT &&
							plan_len[(start + pick) % kqsb_pkg::QUEUE_COUNT] == 0) begin
						pick++;
					end
					if (pick < kqsb_pkg::QUEUE_COUNT) begin
						w.queue_index = kqsb_pkg::QIDX_W'((start + pick) %
							kqsb_pkg::QUEUE_COUNT);
					end
				end
				push_word(w);
				burst--;
				left--;
			end
			mode = traffic_mode_t'($urandom_range(MODE_NOISE));
			burst = $urandom_range(20, 120);
		end

		// Reset is released through a nonblocking write, so the block still sees it
		// low at this edge.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_count < command_words.size()) begin
			@(posedge clk);
		end
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		// Any stray result word after the last expected one is caught by the receiver.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: files.f
design/kqsb_pkg.sv
design/kqsb_ram.sv
design/k_queues_shared_buffer.sv
sim/tb_k_queues_shared_buffer.sv
